/* hdl/assert_macros.svh */
// Assertion macros used by the days-between-dates unit.
// Each macro checks an implication on the rising clock edge, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, c holds too.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication: when a holds, c holds in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* hdl/gdb_pkg.sv */
// Shared widths, constants and calendar tables for the days-between-dates unit.
// No dependencies.
package gdb_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int DNUM_W   = 23;              // day number of any 14-bit year
    localparam int DIV_IN_W = YEAR_W + 1;      // dividend of the divide-by-100 unit
    localparam int QUOT_W   = 8;               // quotient by 100 of a dividend up to 16482
    localparam int RECIP_W  = 14;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_100 = 14'd10486;   // ceil(2^20 / 100)
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Days in the year before the first of month m; zero for invalid codes.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Length of month m; zero for invalid codes.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] v;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/gregorian_days_between_dates_unit.sv */
// Days between two Gregorian dates, from per-date day numbers.
// The sequencer walks each date in turn through the shared divider, ST_Q0 to ST_LEAP, then
// ST_DIFF registers the count and raises o_done; start is taken only in ST_IDLE, so a new
// pair of dates waits until the last is done. busy is high while the sequencer is not idle.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
`include "assert_macros.svh"

module gregorian_days_between_dates_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gdb_pkg::YEAR_W-1:0]  i_start_year,
    input  logic [gdb_pkg::MONTH_W-1:0] i_start_month,
    input  logic [gdb_pkg::DAY_W-1:0]   i_start_day,
    input  logic [gdb_pkg::YEAR_W-1:0]  i_end_year,
    input  logic [gdb_pkg::MONTH_W-1:0] i_end_month,
    input  logic [gdb_pkg::DAY_W-1:0]   i_end_day,
    output logic                        o_done,
    output logic [gdb_pkg::COUNT_W-1:0] o_day_count,
    output logic                        o_bad_date
);
    import gdb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_LEAP,
        ST_DIFF
    } t_state;

    t_state              r_state;
    logic                r_busy;
    logic                r_done;
    logic                r_side;
    logic                r_bad;
    logic                r_c100;
    logic [YEAR_W-1:0]   r_sy, r_ey;
    logic [MONTH_W-1:0]  r_sm, r_em;
    logic [DAY_W-1:0]    r_sd, r_ed;
    logic [DNUM_W-1:0]   r_acc;
    logic [DNUM_W-1:0]   r_a;
    logic [COUNT_W-1:0]  r_count;

    logic [YEAR_W-1:0]   y;
    logic [MONTH_W-1:0]  m;
    logic [DAY_W-1:0]    d;
    logic [DIV_IN_W-1:0] y99, y399, y3;
    logic [DIV_IN_W-1:0] div_x;
    logic [QUOT_W-1:0]   q;
    logic [DIV_IN_W-1:0] q_x100;
    logic                leap;
    logic [DAY_W-1:0]    mlen;
    logic                date_ok;
    logic [DNUM_W-1:0]   n_acc_base;
    logic [DNUM_W-1:0]   n_acc_leap;
    logic [DNUM_W-1:0]   diff;

    assign y = r_side ? r_ey : r_sy;
    assign m = r_side ? r_em : r_sm;
    assign d = r_side ? r_ed : r_sd;

    assign y99  = DIV_IN_W'(y) + DIV_IN_W'(99);
    assign y399 = DIV_IN_W'(y) + DIV_IN_W'(399);
    assign y3   = DIV_IN_W'(y) + DIV_IN_W'(3);

    // Operand sequence per date: y+99, (y+399)/4, y, y/4; each quotient is registered and used by the next state.
    always_comb begin
        case (r_state)
            ST_Q0:   div_x = y99;
            ST_Q1:   div_x = DIV_IN_W'(y399[DIV_IN_W-1:2]);
            ST_Q3:   div_x = DIV_IN_W'(y[YEAR_W-1:2]);
            default: div_x = DIV_IN_W'(y);
        endcase
    end

    gdb_div100 u_div (
        .i_clk (i_clk),
        .i_x   (div_x),
        .o_q   (q)
    );

    assign q_x100 = DIV_IN_W'(q) * DIV_IN_W'(100);

    // In ST_LEAP, q is (y/4)/100 and r_c100 says y is a multiple of 100.
    assign leap = (y[1:0] == 2'b00) &&
                  (!r_c100 || (q_x100 == DIV_IN_W'(y[YEAR_W-1:2])));
    assign mlen = month_length(m, leap);
    assign date_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
                     (d != '0) && (d <= mlen);

    assign n_acc_base = DNUM_W'(y) * DNUM_W'(365) + DNUM_W'(y3[DIV_IN_W-1:2]);
    assign n_acc_leap = r_acc + DNUM_W'(days_before_month(m)) + DNUM_W'(d)
                      - DNUM_W'(1) + DNUM_W'((m > MONTH_FEB) && leap);

    assign diff = r_acc - r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_side  <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_sy    <= i_start_year;
                        r_sm    <= i_start_month;
                        r_sd    <= i_start_day;
                        r_ey    <= i_end_year;
                        r_em    <= i_end_month;
                        r_ed    <= i_end_day;
                        r_side  <= 1'b0;
                        r_bad   <= 1'b0;
                        r_busy  <= 1'b1;
                        r_state <= ST_Q0;
                    end
                end
                ST_Q0: begin
                    r_acc   <= n_acc_base;
                    r_state <= ST_Q1;
                end
                ST_Q1: begin
                    r_acc   <= r_acc - DNUM_W'(q);
                    r_state <= ST_Q2;
                end
                ST_Q2: begin
                    r_acc   <= r_acc + DNUM_W'(q);
                    r_state <= ST_Q3;
                end
                ST_Q3: begin
                    r_c100  <= (q_x100 == DIV_IN_W'(y));
                    r_state <= ST_LEAP;
                end
                ST_LEAP: begin
                    r_bad <= r_bad | !date_ok;
                    if (!r_side) begin
                        r_a     <= n_acc_leap;
                        r_side  <= 1'b1;
                        r_state <= ST_Q0;
                    end else begin
                        r_acc   <= n_acc_leap;
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    if (r_bad || (r_a >= r_acc)) begin
                        r_count <= '0;
                    end else if (diff > DNUM_W'(COUNT_MAX)) begin
                        r_count <= COUNT_MAX;
                    end else begin
                        r_count <= diff[COUNT_W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_busy  <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_done      = r_done;
    assign o_day_count = r_count;
    assign o_bad_date  = r_bad;

    `ASSERT_NEXT(a_start_sets_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, o_done, !busy && (r_state == ST_IDLE))
    `ASSERT_IMPL(a_bad_gives_zero, i_clk, i_rst_n, o_done && o_bad_date, o_day_count == '0)
    `ASSERT_IMPL(a_busy_matches_seq, i_clk, i_rst_n, busy, r_state != ST_IDLE)

endmodule

/* hdl/gdb_div100.sv */
// Shared divide-by-100 unit: reciprocal multiply with a registered quotient.
// Depends on gdb_pkg.
module gdb_div100 (
    input  logic                         i_clk,
    input  logic [gdb_pkg::DIV_IN_W-1:0] i_x,
    output logic [gdb_pkg::QUOT_W-1:0]   o_q
);
    import gdb_pkg::*;

    localparam int PROD_W = DIV_IN_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] r_q;

    // Exact for dividends below 43690, above the 15-bit range; o_q keeps quotients below 256.
    assign prod = PROD_W'(i_x) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        r_q <= prod[RECIP_SHIFT +: QUOT_W];
    end

    assign o_q = r_q;

endmodule
